@@ sv/tilt_orientation_rotator_unit_defines.svh @@
`ifndef TILT_ORIENTATION_ROTATOR_UNIT_DEFINES_SVH
`define TILT_ORIENTATION_ROTATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TOR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tor: assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TOR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tor: assertion failed");

`endif

@@ sv/tor_pkg.sv @@
`timescale 1ns / 1ps

package tor_pkg;

	localparam logic [1:0] REG_Z_CEILING  = 2'd0;
	localparam logic [1:0] REG_MIN_ENERGY = 2'd1;
	localparam logic [1:0] REG_DOM_RATIO  = 2'd2;
	localparam logic [1:0] REG_UNUSED     = 2'd3;

	localparam logic [7:0] DOM_RATIO_RESET = 8'd32;

	localparam logic [2:0] POSE_NORMAL = 3'd0;
	localparam logic [2:0] POSE_D90    = 3'd1;
	localparam logic [2:0] POSE_D180   = 3'd2;
	localparam logic [2:0] POSE_D270   = 3'd3;
	localparam logic [2:0] POSE_KEEP   = 3'd4;

	localparam logic [0:0] REQ_SAMPLE = 1'b0;
	localparam logic [0:0] REQ_SWITCH = 1'b1;

	localparam logic [1:0] ROT_0 = 2'd0;
	localparam logic [1:0] ROT_1 = 2'd1;
	localparam logic [1:0] ROT_2 = 2'd2;
	localparam logic [1:0] ROT_3 = 2'd3;

	typedef struct packed {
		logic signed [15:0] z_ceiling;
		logic [31:0]        min_energy;
		logic [7:0]         dom_ratio;
	} cfg_t;

	typedef struct packed {
		logic        req_type;
		logic        switch_level;
		logic        z_upright;
		logic        x_pos;
		logic        y_pos;
		logic [15:0] ax;
		logic [15:0] ay;
		logic [30:0] sq_x;
		logic [30:0] sq_y;
		logic [23:0] ax_r;
		logic [23:0] ay_r;
	} prod_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] rot;
		logic [1:0] note;
	} cmd_t;

	function automatic cmd_t pose_cmd(input logic [2:0] cls);
		cmd_t c;
		c = '0;
		unique case (cls)
			POSE_NORMAL: c = '{valid: 1'b1, rot: ROT_2, note: ROT_2};
			POSE_D90:    c = '{valid: 1'b1, rot: ROT_1, note: ROT_3};
			POSE_D180:   c = '{valid: 1'b1, rot: ROT_0, note: ROT_0};
			POSE_D270:   c = '{valid: 1'b1, rot: ROT_3, note: ROT_1};
			default:     c = '0;
		endcase
		return c;
	endfunction

endpackage

@@ sv/tor_product_stage.sv @@
`timescale 1ns / 1ps

module tor_product_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  tor_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic signed [15:0]  accel_x,
	input  logic signed [15:0]  accel_y,
	input  logic signed [15:0]  accel_z,
	input  logic                switch_level,
	output logic                prod_valid,
	input  logic                prod_ready,
	output tor_pkg::prod_t      prod
);
	import tor_pkg::*;

	logic               valid_s1;
	logic               req_type_s1;
	logic               switch_level_s1;
	logic signed [15:0] x_s1;
	logic signed [15:0] y_s1;
	logic signed [15:0] z_s1;
	logic               valid_s2;
	prod_t              prod_s2;
	logic               s1_ready;
	logic               s2_ready;
	logic [15:0]        ax;
	logic [15:0]        ay;
	prod_t              prod_next;

	assign s2_ready = !valid_s2 || prod_ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign in_stall = !s1_ready;

	assign ax = x_s1[15] ? 16'(~x_s1 + 16'sd1) : 16'(x_s1);
	assign ay = y_s1[15] ? 16'(~y_s1 + 16'sd1) : 16'(y_s1);

	always_comb begin
		prod_next.req_type     = req_type_s1;
		prod_next.switch_level = switch_level_s1;
		prod_next.z_upright    = z_s1 <= cfg.z_ceiling;
		prod_next.x_pos        = !x_s1[15] && (x_s1 != 16'sd0);
		prod_next.y_pos        = !y_s1[15] && (y_s1 != 16'sd0);
		prod_next.ax           = ax;
		prod_next.ay           = ay;
		prod_next.sq_x         = 31'({16'd0, ax} * {16'd0, ax});
		prod_next.sq_y         = 31'({16'd0, ay} * {16'd0, ay});
		prod_next.ax_r         = {8'd0, ax} * {16'd0, cfg.dom_ratio};
		prod_next.ay_r         = {8'd0, ay} * {16'd0, cfg.dom_ratio};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && in_valid) begin
			req_type_s1     <= req_type;
			switch_level_s1 <= switch_level;
			x_s1            <= accel_x;
			y_s1            <= accel_y;
			z_s1            <= accel_z;
		end
		if (s2_ready && valid_s1) begin
			prod_s2 <= prod_next;
		end
	end

	assign prod_valid = valid_s2;
	assign prod       = prod_s2;

endmodule

@@ sv/tor_decide_stage.sv @@
`timescale 1ns / 1ps
`include "tilt_orientation_rotator_unit_defines.svh"

module tor_decide_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  tor_pkg::cfg_t  cfg,
	input  logic           prod_valid,
	output logic           prod_ready,
	input  tor_pkg::prod_t prod,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [2:0]     pose_class,
	output logic           rotate_valid,
	output logic [1:0]     screen_rotation,
	output logic [1:0]     notify_pose,
	output logic           in_tablet_mode
);
	import tor_pkg::*;

	logic        out_valid_q;
	logic [2:0]  pose_class_q;
	logic        rotate_valid_q;
	logic [1:0]  screen_rotation_q;
	logic [1:0]  notify_pose_q;
	logic        in_tablet_q;
	logic [2:0]  last_pose_q;
	logic        tablet_q;

	logic        out_load;
	logic [31:0] energy;
	logic        upright;
	logic        x_dom;
	logic        y_dom;
	logic [2:0]  cls;
	logic [2:0]  res_cls;
	cmd_t        cmd;
	logic        tablet_next;
	logic [2:0]  last_pose_next;

	assign prod_ready = !out_valid_q || !out_stall;
	assign out_load   = prod_valid && prod_ready;

	assign energy  = {1'b0, prod.sq_x} + {1'b0, prod.sq_y};
	assign upright = prod.z_upright && (energy >= cfg.min_energy);
	assign x_dom   = {4'd0, prod.ax, 4'd0} >= prod.ay_r;
	assign y_dom   = {4'd0, prod.ay, 4'd0} >= prod.ax_r;

	always_comb begin
		cls = POSE_KEEP;
		if (upright) begin
			priority if (x_dom) begin
				cls = prod.x_pos ? POSE_D90 : POSE_D270;
			end else if (y_dom) begin
				cls = prod.y_pos ? POSE_NORMAL : POSE_D180;
			end else begin
				cls = POSE_KEEP;
			end
		end
	end

	always_comb begin
		res_cls        = POSE_KEEP;
		cmd            = '0;
		tablet_next    = tablet_q;
		last_pose_next = last_pose_q;
		if (prod.req_type == REQ_SAMPLE) begin
			res_cls = cls;
			if (tablet_q && (cls != last_pose_q)) begin
				last_pose_next = cls;
				cmd            = pose_cmd(cls);
			end
		end else begin
			if (prod.switch_level && tablet_q) begin
				tablet_next = 1'b0;
				cmd         = '{valid: 1'b1, rot: ROT_0, note: ROT_0};
			end else if (!prod.switch_level && !tablet_q) begin
				tablet_next = 1'b1;
				cmd         = '{valid: 1'b1, rot: ROT_2, note: ROT_2};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_pose_q <= POSE_NORMAL;
			tablet_q    <= 1'b0;
		end else begin
			if (prod_ready) begin
				out_valid_q <= prod_valid;
			end
			if (out_load) begin
				last_pose_q <= last_pose_next;
				tablet_q    <= tablet_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pose_class_q      <= res_cls;
			rotate_valid_q    <= cmd.valid;
			screen_rotation_q <= cmd.rot;
			notify_pose_q     <= cmd.note;
			in_tablet_q       <= tablet_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign pose_class      = pose_class_q;
	assign rotate_valid    = rotate_valid_q;
	assign screen_rotation = screen_rotation_q;
	assign notify_pose     = notify_pose_q;
	assign in_tablet_mode  = in_tablet_q;

	`TOR_ASSERT_NEXT(a_switch_keeps_pose, clk, arst_n, out_load && prod.req_type, $stable(last_pose_q))
	`TOR_ASSERT_NEXT(a_mode_only_on_switch, clk, arst_n, !(out_load && prod.req_type), $stable(tablet_q))
	`TOR_ASSERT_NEXT(a_new_pose_stored, clk, arst_n, out_load && !prod.req_type && tablet_q && (cls != last_pose_q), last_pose_q == $past(cls))
	`TOR_ASSERT_SAME(a_idle_cmd_zero, clk, arst_n, out_valid_q && !rotate_valid_q, (screen_rotation_q == ROT_0) && (notify_pose_q == ROT_0))

endmodule

@@ sv/tilt_orientation_rotator_unit.sv @@
`timescale 1ns / 1ps

// Tilt orientation rotator.
// Input channel (in_valid / in_stall) carries one transaction per item: either an
// accelerometer sample (req_type 0, accel_x/y/z) or a lid switch reading
// (req_type 1, switch_level). Output channel (out_valid / out_stall) returns
// exactly one result transaction per input transaction, in order.
// Each accepted transaction passes through the input register, the product
// register and the result register. Throughput is one transaction per cycle
// while out_stall stays low; the squares and ratio products are one registered
// stage, the compares and the pose/mode state update are the next.
// When the receiver stalls, the result register holds; upstream stages keep
// accepting until they fill, then in_stall rises.
// Configuration: cfg_wr_en with cfg_index 0 z_ceiling, 1 min_planar_energy,
// 2 dominance_ratio (4 fraction bits); index 3 is ignored. Write only while idle.
// Reset (arst_n low) empties the pipeline, restores register defaults
// (ratio 2.0), clamshell mode and normal pose.
module tilt_orientation_rotator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic               switch_level,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         pose_class,
	output logic               rotate_valid,
	output logic [1:0]         screen_rotation,
	output logic [1:0]         notify_pose,
	output logic               in_tablet_mode
);
	import tor_pkg::*;

	cfg_t  cfg_q;
	logic  prod_valid;
	logic  prod_ready;
	prod_t prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.z_ceiling  <= 16'sd0;
			cfg_q.min_energy <= 32'd0;
			cfg_q.dom_ratio  <= DOM_RATIO_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_Z_CEILING:  cfg_q.z_ceiling  <= cfg_wdata[15:0];
				REG_MIN_ENERGY: cfg_q.min_energy <= cfg_wdata;
				REG_DOM_RATIO:  cfg_q.dom_ratio  <= cfg_wdata[7:0];
				REG_UNUSED:     ;
				default:        ;
			endcase
		end
	end

	tor_product_stage u_product (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.switch_level (switch_level),
		.prod_valid   (prod_valid),
		.prod_ready   (prod_ready),
		.prod         (prod)
	);

	tor_decide_stage u_decide (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.prod_valid      (prod_valid),
		.prod_ready      (prod_ready),
		.prod            (prod),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pose_class      (pose_class),
		.rotate_valid    (rotate_valid),
		.screen_rotation (screen_rotation),
		.notify_pose     (notify_pose),
		.in_tablet_mode  (in_tablet_mode)
	);

endmodule

@@ sim/tilt_orientation_rotator_checker.sv @@
`timescale 1ns / 1ps

module tilt_orientation_rotator_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               req_type,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic               switch_level,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [2:0]         pose_class,
	input  logic               rotate_valid,
	input  logic [1:0]         screen_rotation,
	input  logic [1:0]         notify_pose,
	input  logic               in_tablet_mode,
	output int                 fail_count,
	output int                 pending,
	output int                 results_seen,
	output int                 commands_seen
);
	import tor_pkg::*;

	typedef struct packed {
		logic [2:0] pose;
		logic       cmd;
		logic [1:0] rot;
		logic [1:0] note;
		logic       tablet;
	} orient_t;

	orient_t            orient_queue[$];
	logic signed [15:0] z_ceil;
	logic [31:0]        energy_floor;
	logic [7:0]         ratio;
	logic [2:0]         held_pose;
	logic               tablet;

	function automatic logic [2:0] classify_tilt(input logic signed [15:0] x, y, z);
		longint ax, ay;
		ax = (x < 0) ? -longint'(x) : longint'(x);
		ay = (y < 0) ? -longint'(y) : longint'(y);
		if (z > z_ceil || (ax * ax + ay * ay) < longint'(energy_floor))
			return POSE_KEEP;
		if (ax * 16 >= ay * longint'(ratio))
			return (x > 0) ? POSE_D90 : POSE_D270;
		if (ay * 16 >= ax * longint'(ratio))
			return (y > 0) ? POSE_NORMAL : POSE_D180;
		return POSE_KEEP;
	endfunction

	function automatic orient_t predict_orientation(input logic kind,
			input logic signed [15:0] x, y, z, input logic lvl);
		orient_t r;
		r = '{pose: POSE_KEEP, cmd: 1'b0, rot: ROT_0, note: ROT_0, tablet: 1'b0};
		if (kind == REQ_SAMPLE) begin
			r.pose = classify_tilt(x, y, z);
			if (tablet && r.pose != held_pose) begin
				held_pose = r.pose;
				case (r.pose)
					POSE_NORMAL: {r.cmd, r.rot, r.note} = {1'b1, ROT_2, ROT_2};
					POSE_D90:    {r.cmd, r.rot, r.note} = {1'b1, ROT_1, ROT_3};
					POSE_D180:   {r.cmd, r.rot, r.note} = {1'b1, ROT_0, ROT_0};
					POSE_D270:   {r.cmd, r.rot, r.note} = {1'b1, ROT_3, ROT_1};
					default:     ;
				endcase
			end
		end else if (lvl && tablet) begin
			tablet = 1'b0;
			{r.cmd, r.rot, r.note} = {1'b1, ROT_0, ROT_0};
		end else if (!lvl && !tablet) begin
			tablet = 1'b1;
			{r.cmd, r.rot, r.note} = {1'b1, ROT_2, ROT_2};
		end
		r.tablet = tablet;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("%0t result %0d: %s", $time, results_seen, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		orient_t want;
		if (!arst_n) begin
			z_ceil       = '0;
			energy_floor = '0;
			ratio        = DOM_RATIO_RESET;
			held_pose    = POSE_NORMAL;
			tablet       = 1'b0;
			orient_queue.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_Z_CEILING:  z_ceil = cfg_wdata[15:0];
					REG_MIN_ENERGY: energy_floor = cfg_wdata;
					REG_DOM_RATIO:  ratio = cfg_wdata[7:0];
					default:        ;
				endcase
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (rotate_valid === 1'b1)
					commands_seen++;
				if (orient_queue.size() == 0) begin
					report_mismatch("transaction with no result pending");
				end else begin
					want = orient_queue.pop_front();
					if (pose_class !== want.pose)
						report_mismatch($sformatf("pose_class %0d, want %0d",
							pose_class, want.pose));
					if (rotate_valid !== want.cmd)
						report_mismatch($sformatf("rotate_valid %0b, want %0b",
							rotate_valid, want.cmd));
					if (screen_rotation !== want.rot)
						report_mismatch($sformatf("screen_rotation %0d, want %0d",
							screen_rotation, want.rot));
					if (notify_pose !== want.note)
						report_mismatch($sformatf("notify_pose %0d, want %0d",
							notify_pose, want.note));
					if (in_tablet_mode !== want.tablet)
						report_mismatch($sformatf("in_tablet_mode %0b, want %0b",
							in_tablet_mode, want.tablet));
				end
			end
			if (in_valid && !in_stall)
				orient_queue.push_back(predict_orientation(req_type, accel_x, accel_y,
					accel_z, switch_level));
		end
		pending = orient_queue.size();
	end

endmodule

@@ sim/tilt_orientation_rotator_unit_test.sv @@
`timescale 1ns / 1ps

module tilt_orientation_rotator_unit_test;
	import tor_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES       = 9;
	localparam int PHASE_ITEMS  = 65;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic               req_type;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic               switch_level;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         pose_class;
	logic               rotate_valid;
	logic [1:0]         screen_rotation;
	logic [1:0]         notify_pose;
	logic               in_tablet_mode;

	int fail_count, pending, results_seen, commands_seen;
	int idle_cycles, sent, settings_used;
	logic calm_in, calm_out;

	// copy of the register settings, used to shape samples
	logic signed [15:0] cur_z_ceil;
	logic [7:0]         cur_ratio;

	tilt_orientation_rotator_unit u_top (.*);

	tilt_orientation_rotator_checker u_check (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: %0d cycles without a transaction", idle_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int n;
		out_stall = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			n = calm_out ? 0 : $urandom_range(0, 5);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	task automatic push_item(input logic kind, input logic signed [15:0] x, y, z,
			input logic lvl);
		int gap;
		gap = calm_in ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= kind;
		accel_x      <= x;
		accel_y      <= y;
		accel_z      <= z;
		switch_level <= lvl;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic push_sample();
		logic signed [15:0] x, y, z;
		logic [31:0]        raw;
		int                 shape, major, minor, zc;
		shape = $urandom_range(0, 9);
		raw   = $urandom;
		if (shape < 2) begin
			x = raw[15:0];
			y = raw[31:16];
		end else if (shape < 7) begin
			// one axis clearly larger, magnitude spread over all scales
			major = $urandom_range(1, (1 << $urandom_range(1, 15)) - 1);
			minor = $urandom_range(0, major / 3);
			x = raw[0] ? -major : major;
			y = raw[1] ? -minor : minor;
		end else if (shape < 9) begin
			// right at the dominance boundary
			minor = $urandom_range(0, 2047);
			major = (minor * int'(cur_ratio)) / 16 + int'($urandom_range(0, 2)) - 1;
			if (major < 0)
				major = 0;
			x = raw[0] ? -major : major;
			y = raw[1] ? -minor : minor;
		end else begin
			x = int'($urandom_range(0, 4)) - 2;
			y = int'($urandom_range(0, 4)) - 2;
		end
		if (raw[2])
			{x, y} = {y, x};
		zc = cur_z_ceil;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: z = zc - int'($urandom_range(0, zc + 32768));
			6:                z = cur_z_ceil;
			7:                z = cur_z_ceil + 16'sd1;
			default:          z = $urandom;
		endcase
		push_item(REQ_SAMPLE, x, y, z, raw[3]);
	endtask

	// let the pipeline empty before anything that needs the block idle
	task automatic drain_block();
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic load_settings(input logic signed [15:0] zc, input logic [31:0] floor_val,
			input logic [7:0] r);
		logic [31:0] junk;
		junk = $urandom;
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_Z_CEILING;
		cfg_wdata <= {junk[31:16], zc};
		@(negedge clk);
		cfg_index <= REG_MIN_ENERGY;
		cfg_wdata <= floor_val;
		@(negedge clk);
		cfg_index <= REG_DOM_RATIO;
		cfg_wdata <= {junk[23:0], r};
		@(negedge clk);
		cfg_index <= REG_UNUSED;
		cfg_wdata <= $urandom;
		@(negedge clk);
		cfg_wr_en  <= 1'b0;
		cur_z_ceil = zc;
		cur_ratio  = r;
		settings_used++;
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_index    = REG_Z_CEILING;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		req_type     = REQ_SAMPLE;
		accel_x      = '0;
		accel_y      = '0;
		accel_z      = '0;
		switch_level = 1'b0;
		calm_in      = 1'b0;
		calm_out     = 1'b0;
		cur_z_ceil   = '0;
		cur_ratio    = DOM_RATIO_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: ceiling 0, no energy floor, ratio 2.0
		push_item(REQ_SAMPLE, 32767, 0, -1, 1'b0);
		push_item(REQ_SWITCH, 0, 0, 0, 1'b1);
		push_item(REQ_SWITCH, 0, 0, 0, 1'b0);
		push_item(REQ_SWITCH, 0, 0, 0, 1'b0);
		push_item(REQ_SAMPLE, 0, 32767, 0, 1'b0);
		push_item(REQ_SAMPLE, 32767, 100, -32768, 1'b0);
		push_item(REQ_SAMPLE, 32767, 0, -5, 1'b0);
		push_item(REQ_SAMPLE, 0, -32768, -1, 1'b0);
		push_item(REQ_SAMPLE, -32768, 0, -1, 1'b0);
		push_item(REQ_SAMPLE, 0, 0, 0, 1'b0);
		push_item(REQ_SAMPLE, 0, 32767, -1, 1'b0);
		push_item(REQ_SAMPLE, 0, 0, -1, 1'b0);
		push_item(REQ_SAMPLE, 100, 100, -1, 1'b0);
		push_item(REQ_SAMPLE, 100, 100, -1, 1'b0);
		push_item(REQ_SAMPLE, 0, 500, 1, 1'b0);
		push_item(REQ_SAMPLE, 0, 500, 32767, 1'b0);
		push_item(REQ_SAMPLE, -32768, -32768, -32768, 1'b0);
		push_item(REQ_SAMPLE, -32768, 16384, -1, 1'b0);
		push_item(REQ_SAMPLE, -16383, 32766, -1, 1'b0);
		push_item(REQ_SWITCH, 0, 0, 0, 1'b1);
		push_item(REQ_SAMPLE, 0, -32768, -1, 1'b0);
		push_item(REQ_SWITCH, 0, 0, 0, 1'b0);
		drain_block();
		load_settings(16'sd0, 32'd1000, 8'd16);
		push_item(REQ_SAMPLE, 31, 0, -1, 1'b0);
		push_item(REQ_SAMPLE, 31, 10, -1, 1'b0);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_block();
			case (ph)
				0:       load_settings(16'sh7FFF, 32'd0, 8'd255);
				1:       load_settings(16'sh8000, 32'h8000_0000, 8'd0);
				2:       load_settings(16'sd0, 32'd0, 8'd16);
				3:       load_settings(16'sh8000, 32'd0, 8'd0);
				default: load_settings($urandom,
					$urandom & ((32'h1 << $urandom_range(0, 31)) - 32'h1), $urandom);
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 20 == 0) begin
					calm_in  = ($urandom_range(0, 3) == 0);
					calm_out = ($urandom_range(0, 3) == 0);
				end
				if (n == PHASE_ITEMS / 2 && (ph == 2 || $urandom_range(0, 1) == 1))
					drain_block();
				if ($urandom_range(0, 9) == 0)
					push_item(REQ_SWITCH, $urandom, $urandom, $urandom,
						$urandom_range(0, 3) == 0);
				else
					push_sample();
			end
		end

		drain_block();
		$display("%0d transactions over %0d register settings, %0d results compared",
			sent, settings_used, results_seen);
		$display("%0d rotation commands seen; lid moves, axis extremes and ratio edges hit",
			commands_seen);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
